// File: rtl/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared widths, types and register map for the trilinear interpolation block.
// ----------------------------------------------------------------------------
package tli_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    // Number of corners in a cell, number of axes
    localparam int CORNERS = 8;
    localparam int AXES    = 3;

    // Axis weight: 2^F - f lies in [1, 2^F], so one extra bit
    localparam int WEIGHT_W = FRACTION_BITS + 1;

    // Datapath widths, one per pipeline product/sum
    localparam int PX_W    = SAMPLE_BITS + FRACTION_BITS + 2;       // sample * weight
    localparam int LINE_W  = SAMPLE_BITS + FRACTION_BITS;           // blend along x
    localparam int PY_W    = LINE_W + FRACTION_BITS + 2;            // line * weight
    localparam int PLANE_W = SAMPLE_BITS + 2 * FRACTION_BITS;       // blend along y
    localparam int HI_W    = PLANE_W - FRACTION_BITS;               // upper plane part
    localparam int PH_W    = HI_W + FRACTION_BITS + 2;              // upper part * weight
    localparam int PL_W    = 2 * FRACTION_BITS + 1;                 // lower part * weight
    localparam int HS_W    = PH_W + 1;                              // sum of upper products
    localparam int LS_W    = PL_W + 1;                              // sum of lower products
    localparam int TOT_W   = HS_W + FRACTION_BITS;                  // full blend
    localparam int RES_LSB = 3 * FRACTION_BITS;                     // scale 2^(3F)

    // One half at the scale of the full blend, for round half up
    localparam logic [TOT_W-1:0] ROUND_HALF =
        {{(TOT_W-1){1'b0}}, 1'b1} << (RES_LSB - 1);

    // Unity weight, 2^F
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_FRACTION_THRESHOLD = 1'b0;   // word index of the threshold
    localparam logic [FRACTION_BITS-1:0] THRESHOLD_RESET = FRACTION_BITS'(1);

    // One input transaction as seen by the datapath
    typedef struct packed {
        logic [CORNERS-1:0][SAMPLE_BITS-1:0] corner;   // index x + 2y + 4z
        logic [AXES-1:0][FRACTION_BITS-1:0]  frac;     // x, y, z
    } tli_item_t;

endpackage

// File: rtl/tli_voxel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_voxel_if
// Input channel: eight corner samples and three cell fractions.
// ----------------------------------------------------------------------------
interface tli_voxel_if;
    import tli_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   corner_000;
    logic signed [SAMPLE_BITS-1:0]   corner_100;
    logic signed [SAMPLE_BITS-1:0]   corner_010;
    logic signed [SAMPLE_BITS-1:0]   corner_110;
    logic signed [SAMPLE_BITS-1:0]   corner_001;
    logic signed [SAMPLE_BITS-1:0]   corner_101;
    logic signed [SAMPLE_BITS-1:0]   corner_011;
    logic signed [SAMPLE_BITS-1:0]   corner_111;
    logic        [FRACTION_BITS-1:0] frac_x;
    logic        [FRACTION_BITS-1:0] frac_y;
    logic        [FRACTION_BITS-1:0] frac_z;

    modport source (
        output valid,
        output corner_000, corner_100, corner_010, corner_110,
        output corner_001, corner_101, corner_011, corner_111,
        output frac_x, frac_y, frac_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  corner_000, corner_100, corner_010, corner_110,
        input  corner_001, corner_101, corner_011, corner_111,
        input  frac_x, frac_y, frac_z,
        output ready
    );
endinterface

// File: rtl/tli_blend_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_blend_if
// Output channel: one interpolated sample per transaction.
// ----------------------------------------------------------------------------
interface tli_blend_if;
    import tli_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] blended_value;

    modport source (
        output valid,
        output blended_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  blended_value,
        output ready
    );
endinterface

// File: rtl/tli_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_datapath
// Eight-stage blend pipeline: weights, x products, x sums, y products,
// y sums, z partial products, z sums, round and output register.
// ----------------------------------------------------------------------------
module tli_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  tli_pkg::tli_item_t                 in_item,
    input  logic [tli_pkg::FRACTION_BITS-1:0]  threshold,
    output logic                               out_valid,
    output logic signed [tli_pkg::SAMPLE_BITS-1:0] out_value
);
    import tli_pkg::*;

    localparam int STAGES = 8;

    // Valid bit per stage
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // Stage 1: samples and axis weights
    logic [CORNERS-1:0][SAMPLE_BITS-1:0] samp1_reg;
    logic [AXES-1:0][1:0][WEIGHT_W-1:0]  w1_reg;
    logic [AXES-1:0][1:0][WEIGHT_W-1:0]  w1_next;

    // Stage 2: x products
    logic [CORNERS-1:0][PX_W-1:0]        px2_reg;
    logic [CORNERS-1:0][PX_W-1:0]        px2_next;
    logic [1:0][WEIGHT_W-1:0]            wy2_reg;
    logic [1:0][WEIGHT_W-1:0]            wz2_reg;

    // Stage 3: lines along x
    logic [3:0][LINE_W-1:0]              line3_reg;
    logic [3:0][LINE_W-1:0]              line3_next;
    logic [1:0][WEIGHT_W-1:0]            wy3_reg;
    logic [1:0][WEIGHT_W-1:0]            wz3_reg;

    // Stage 4: y products
    logic [3:0][PY_W-1:0]                py4_reg;
    logic [3:0][PY_W-1:0]                py4_next;
    logic [1:0][WEIGHT_W-1:0]            wz4_reg;

    // Stage 5: planes along y
    logic [1:0][PLANE_W-1:0]             plane5_reg;
    logic [1:0][PLANE_W-1:0]             plane5_next;
    logic [1:0][WEIGHT_W-1:0]            wz5_reg;

    // Stage 6: z partial products, plane split into upper and lower parts
    logic [1:0][PH_W-1:0]                ph6_reg;
    logic [1:0][PH_W-1:0]                ph6_next;
    logic [1:0][PL_W-1:0]                pl6_reg;
    logic [1:0][PL_W-1:0]                pl6_next;

    // Stage 7: partial sums
    logic [HS_W-1:0]                     hs7_reg;
    logic [HS_W-1:0]                     hs7_next;
    logic [LS_W-1:0]                     ls7_reg;
    logic [LS_W-1:0]                     ls7_next;

    // Stage 8: rounded result
    logic [SAMPLE_BITS-1:0]              res8_reg;
    logic [SAMPLE_BITS-1:0]              res8_next;

    // Valid bits shift with the data
    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Threshold and axis weights
    always_comb
    begin
        logic [FRACTION_BITS-1:0] f;
        for (int a = 0; a < AXES; a++)
        begin
            f = (in_item.frac[a] < threshold) ? '0 : in_item.frac[a];
            w1_next[a][0] = WEIGHT_ONE - {1'b0, f};
            w1_next[a][1] = {1'b0, f};
        end
    end

    // x products: corner i takes the x weight of its low index bit
    always_comb
    begin
        for (int i = 0; i < CORNERS; i++)
        begin
            px2_next[i] = $signed(samp1_reg[i]) * $signed({1'b0, w1_reg[0][i % 2]});
        end
    end

    // x sums; exact result fits LINE_W
    always_comb
    begin
        logic [PX_W:0] s;
        for (int i = 0; i < 4; i++)
        begin
            s = {px2_reg[2*i][PX_W-1], px2_reg[2*i]}
                + {px2_reg[2*i+1][PX_W-1], px2_reg[2*i+1]};
            line3_next[i] = s[LINE_W-1:0];
        end
    end

    // y products
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            py4_next[i] = $signed(line3_reg[i]) * $signed({1'b0, wy3_reg[i % 2]});
        end
    end

    // y sums; exact result fits PLANE_W
    always_comb
    begin
        logic [PY_W:0] s;
        for (int i = 0; i < 2; i++)
        begin
            s = {py4_reg[2*i][PY_W-1], py4_reg[2*i]}
                + {py4_reg[2*i+1][PY_W-1], py4_reg[2*i+1]};
            plane5_next[i] = s[PLANE_W-1:0];
        end
    end

    // z products, split so no multiplier exceeds HI_W by WEIGHT_W
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            ph6_next[i] = $signed(plane5_reg[i][PLANE_W-1:FRACTION_BITS])
                          * $signed({1'b0, wz5_reg[i]});
            pl6_next[i] = plane5_reg[i][FRACTION_BITS-1:0] * wz5_reg[i];
        end
    end

    // Partial sums
    always_comb
    begin
        hs7_next = {ph6_reg[0][PH_W-1], ph6_reg[0]} + {ph6_reg[1][PH_W-1], ph6_reg[1]};
        ls7_next = {1'b0, pl6_reg[0]} + {1'b0, pl6_reg[1]};
    end

    // Recombine, add one half, keep the integer part
    always_comb
    begin
        logic [TOT_W-1:0] total;
        total = {hs7_reg, {FRACTION_BITS{1'b0}}}
                + {{(TOT_W-LS_W){1'b0}}, ls7_reg}
                + ROUND_HALF;
        res8_next = total[RES_LSB +: SAMPLE_BITS];
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            samp1_reg  <= in_item.corner;
            w1_reg     <= w1_next;
            px2_reg    <= px2_next;
            wy2_reg    <= w1_reg[1];
            wz2_reg    <= w1_reg[2];
            line3_reg  <= line3_next;
            wy3_reg    <= wy2_reg;
            wz3_reg    <= wz2_reg;
            py4_reg    <= py4_next;
            wz4_reg    <= wz3_reg;
            plane5_reg <= plane5_next;
            wz5_reg    <= wz4_reg;
            ph6_reg    <= ph6_next;
            pl6_reg    <= pl6_next;
            hs7_reg    <= hs7_next;
            ls7_reg    <= ls7_next;
            res8_reg   <= res8_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_value = $signed(res8_reg);

endmodule

// File: rtl/trilinear_interpolation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_interpolation_top
// Trilinear blend of a voxel cell's eight corners with a fraction threshold.
//
// Usage:
//   voxel : sink channel; one transaction carries the eight signed corner
//           samples and the unsigned Q0.16 fractions frac_x, frac_y, frac_z.
//   blend : source channel; one transaction per input, blended_value,
//           rounded half up, in input order.
//   APB   : register 0 (byte address 0) holds fraction_threshold; fractions
//           below it count as zero. Write only while the block is idle.
// blend.valid rises once the transaction reaches the output register; the pipeline
// takes one transaction per cycle while the receiver does not stall it.
// Eight register stages: weights, x products, x sums, y products, y sums,
// split z products, z sums, rounding into the output register.
// Reset empties the pipeline and sets the threshold to 1.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// voxel.ready is low only while the output register is full and not taken.
// ----------------------------------------------------------------------------
module trilinear_interpolation_top (
    input  logic                          clk,
    input  logic                          rst_n,
    tli_voxel_if.sink                     voxel,
    tli_blend_if.source                   blend,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tli_pkg::ADDR_W-1:0]    paddr,
    input  logic [tli_pkg::DATA_W-1:0]    pwdata,
    output logic [tli_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import tli_pkg::*;

    logic [FRACTION_BITS-1:0] threshold_reg;
    logic                     reg_sel;
    logic                     cfg_write;
    logic                     advance;
    tli_item_t                item;

    // APB decode: word index is the address above the byte offset
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[ADDR_W-1:2] == REG_FRACTION_THRESHOLD);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write && reg_sel)
        begin
            threshold_reg <= pwdata[FRACTION_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata[FRACTION_BITS-1:0] = threshold_reg;
        end
    end

    // Pipeline moves unless a finished result is waiting
    assign advance     = !blend.valid || blend.ready;
    assign voxel.ready = advance;

    // Pack the input transaction, corners ordered x + 2y + 4z
    always_comb
    begin
        item.corner[0] = voxel.corner_000;
        item.corner[1] = voxel.corner_100;
        item.corner[2] = voxel.corner_010;
        item.corner[3] = voxel.corner_110;
        item.corner[4] = voxel.corner_001;
        item.corner[5] = voxel.corner_101;
        item.corner[6] = voxel.corner_011;
        item.corner[7] = voxel.corner_111;
        item.frac[0]   = voxel.frac_x;
        item.frac[1]   = voxel.frac_y;
        item.frac[2]   = voxel.frac_z;
    end

    tli_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (voxel.valid),
        .in_item   (item),
        .threshold (threshold_reg),
        .out_valid (blend.valid),
        .out_value (blend.blended_value)
    );

endmodule
